### rtl/core/assert_macros.svh
// Assertion macros for the design files that carry concurrent checks; the formatter is the only one that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define SDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SDF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/sdf_pkg.sv
// Shared constants, types and codes of the signed decimal field formatter.
package sdf_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAX_DIGITS = 20;
  localparam int MAX_FIELD  = 64;

  localparam int BCD_W     = 4 * MAX_DIGITS;
  localparam int CNT_W     = $clog2(VALUE_BITS + 1);
  localparam int DIG_IDX_W = $clog2(MAX_DIGITS);
  localparam int POS_W     = $clog2(MAX_FIELD + 1);
  localparam int PLAN_W    = POS_W + 1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_FIELD_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_JUSTIFY = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PRECISION    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FORCE_PLUS   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SPACE_SIGN   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_PAD     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_LENGTH_MODE  = 3'd6;

  // Length modes.
  localparam logic [1:0] LEN_INT   = 2'd0;
  localparam logic [1:0] LEN_CHAR  = 2'd1;
  localparam logic [1:0] LEN_SHORT = 2'd2;
  localparam logic [1:0] LEN_LONG  = 2'd3;

  // Characters.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NONE  = 8'h00;

  // Status of the binary to decimal converter.
  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

endpackage

### rtl/core/sdf_dabble.sv
// Bit-serial binary to decimal converter using the shift-and-add-three method.
module sdf_dabble (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [sdf_pkg::VALUE_BITS-1:0]      load_mag,
  input  logic [sdf_pkg::CNT_W-1:0]           load_bits,
  output sdf_pkg::conv_stat_t                 stat,
  output logic [sdf_pkg::BCD_W-1:0]           bcd
);

  logic [sdf_pkg::VALUE_BITS-1:0] shift_r, shift_nxt;
  logic [sdf_pkg::BCD_W-1:0]      bcd_r, bcd_nxt, bcd_adj;
  logic [sdf_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;

  // Every decimal digit of five or more gets three added before the doubling.
  always_comb begin
    for (int k = 0; k < sdf_pkg::MAX_DIGITS; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_r[4*k +: 4];
      end
    end
  end

  always_comb begin
    shift_nxt = shift_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      shift_nxt = load_mag;
      bcd_nxt   = '0;
      cnt_nxt   = load_bits;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shift_nxt = {shift_r[sdf_pkg::VALUE_BITS-2:0], 1'b0};
      bcd_nxt   = {bcd_adj[sdf_pkg::BCD_W-2:0], shift_r[sdf_pkg::VALUE_BITS-1]};
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == sdf_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

### rtl/core/signed_decimal_field_formatter.sv
// Signed decimal field formatter: printf %d conversion of one value into ASCII words.
// The converter consumes a value one bit per cycle over its length in bits (8, 16, 32
// or 64); the field's words, at most 64 or one for an empty field, then go out one per
// cycle while the output does not stall. No new value is taken until the last word of
// its field has been registered for output.
// Synchronous active-low reset: idle, width 0, no precision, flags off, 32-bit length.
module signed_decimal_field_formatter (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream: one value per word.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sdf_pkg::VALUE_BITS-1:0]      in_tdata,   // [63:0] value
  // Result stream: one character per word.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [7:0] out_char
  output logic                                out_tlast,
  output logic [0:0]                          out_tuser,  // [0] empty_res
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [sdf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [sdf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // One-hot sequencer: take a value, convert it bit by bit, size the field, then
  // stream the characters out.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CONV  = 6'b000010,
    ST_COUNT = 6'b000100,
    ST_SIZE  = 6'b001000,
    ST_PLAN  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  localparam int VB = sdf_pkg::VALUE_BITS;
  localparam int PW = sdf_pkg::PLAN_W;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [6:0] field_width_r;
  logic       left_justify_r;
  logic [6:0] precision_r;
  logic       force_plus_r;
  logic       space_sign_r;
  logic       zero_pad_r;
  logic [1:0] length_mode_r;

  // Per-value registers.
  logic [7:0]                  sign_r, sign_nxt;
  logic                        has_sign_r, has_sign_nxt;
  logic                        zero_r, zero_nxt;
  logic [sdf_pkg::DIG_IDX_W:0] nd_r, nd_nxt;
  logic [PW-1:0]               zeros_r, zeros_nxt;
  logic [PW-1:0]               dlen_r, dlen_nxt;
  logic [PW-1:0]               pad_r, pad_nxt;
  logic [PW-1:0]               b1_r, b1_nxt;
  logic [PW-1:0]               b2_r, b2_nxt;
  logic [PW-1:0]               b3_r, b3_nxt;
  logic [PW-1:0]               b4_r, b4_nxt;
  logic [PW-1:0]               end_r, end_nxt;
  logic [sdf_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                        plan_load_r;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_empty_r, out_empty_nxt;

  // Converter interface.
  logic                         conv_start;
  logic [VB-1:0]                conv_mag;
  logic [sdf_pkg::CNT_W-1:0]    conv_bits;
  sdf_pkg::conv_stat_t          conv_stat;
  logic [sdf_pkg::BCD_W-1:0]    conv_bcd;
  logic [3:0]                   digit [sdf_pkg::MAX_DIGITS];

  logic          in_fire;
  logic [VB-1:0] val_ext;
  logic [VB-1:0] val_mag;
  logic          val_neg;

  logic          prec_given;
  logic [PW-1:0] prec_val;
  logic [PW-1:0] nd_w;
  logic [PW-1:0] wid;
  logic [PW-1:0] body;
  logic          show;
  logic          zpad_mode;
  logic [PW-1:0] lead, zcnt, trail, total;

  logic [PW-1:0]                  pos_w;
  logic [PW-1:0]                  dig_off;
  logic [sdf_pkg::DIG_IDX_W-1:0]  dig_idx;
  logic [3:0]                     dig_val;
  logic [7:0]                     emit_char;
  logic                           emit_last;
  logic                           emit_empty;
  logic                           out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Configuration writes; the user does them only while idle; not enforced by the block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r  <= '0;
      left_justify_r <= 1'b0;
      precision_r    <= 7'h7F;
      force_plus_r   <= 1'b0;
      space_sign_r   <= 1'b0;
      zero_pad_r     <= 1'b0;
      length_mode_r  <= sdf_pkg::LEN_INT;
    end else if (cfg_we) begin
      case (cfg_addr)
        sdf_pkg::REG_FIELD_WIDTH:  field_width_r  <= cfg_wdata;
        sdf_pkg::REG_LEFT_JUSTIFY: left_justify_r <= cfg_wdata[0];
        sdf_pkg::REG_PRECISION:    precision_r    <= cfg_wdata;
        sdf_pkg::REG_FORCE_PLUS:   force_plus_r   <= cfg_wdata[0];
        sdf_pkg::REG_SPACE_SIGN:   space_sign_r   <= cfg_wdata[0];
        sdf_pkg::REG_ZERO_PAD:     zero_pad_r     <= cfg_wdata[0];
        sdf_pkg::REG_LENGTH_MODE:  length_mode_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Cut the value to its length, sign extend it, and left-align the magnitude so
  // that the converter shifts in only the bits of that length.
  always_comb begin
    case (length_mode_r)
      sdf_pkg::LEN_CHAR: begin
        val_ext   = {{(VB-8){in_tdata[7]}}, in_tdata[7:0]};
        conv_bits = sdf_pkg::CNT_W'(8);
      end
      sdf_pkg::LEN_SHORT: begin
        val_ext   = {{(VB-16){in_tdata[15]}}, in_tdata[15:0]};
        conv_bits = sdf_pkg::CNT_W'(16);
      end
      sdf_pkg::LEN_LONG: begin
        val_ext   = in_tdata;
        conv_bits = sdf_pkg::CNT_W'(VB);
      end
      default: begin
        val_ext   = {{(VB-32){in_tdata[31]}}, in_tdata[31:0]};
        conv_bits = sdf_pkg::CNT_W'(32);
      end
    endcase
    val_neg = val_ext[VB-1];
    // The most negative value wraps to a magnitude with only the top bit set,
    // which is read as unsigned and so comes out right.
    val_mag = val_neg ? (~val_ext + 1'b1) : val_ext;
    case (length_mode_r)
      sdf_pkg::LEN_CHAR:  conv_mag = val_mag << (VB - 8);
      sdf_pkg::LEN_SHORT: conv_mag = val_mag << (VB - 16);
      sdf_pkg::LEN_LONG:  conv_mag = val_mag;
      default:            conv_mag = val_mag << (VB - 32);
    endcase
  end

  assign conv_start = in_fire;

  sdf_dabble u_dabble (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (conv_start),
    .load_mag  (conv_mag),
    .load_bits (conv_bits),
    .stat      (conv_stat),
    .bcd       (conv_bcd)
  );

  always_comb begin
    for (int k = 0; k < sdf_pkg::MAX_DIGITS; k++) begin
      digit[k] = conv_bcd[4*k +: 4];
    end
  end

  // Field sizing. A negative precision means none was given.
  always_comb begin
    prec_given = !precision_r[6];
    prec_val   = PW'(precision_r[5:0]);
    nd_w       = PW'(nd_r);
    if (field_width_r > 7'(sdf_pkg::MAX_FIELD)) begin
      wid = PW'(sdf_pkg::MAX_FIELD);
    end else begin
      wid = PW'(field_width_r);
    end
    // Zero with a precision of zero prints no digits at all.
    show = !(prec_given && (prec_val == '0) && zero_r);
    if (prec_given && (prec_val > nd_w)) begin
      zeros_nxt = prec_val - nd_w;
    end else begin
      zeros_nxt = '0;
    end
    dlen_nxt = show ? nd_w : '0;
    body     = PW'(has_sign_r) + zeros_r + dlen_r;
    pad_nxt  = (wid > body) ? (wid - body) : '0;
  end

  // The field is lead spaces, sign, zeros, digits and trail spaces; the padding
  // goes to exactly one of the lead spaces, the zeros or the trail spaces.
  always_comb begin
    zpad_mode = !left_justify_r && zero_pad_r && !prec_given;
    lead      = (!left_justify_r && !zpad_mode) ? pad_r : '0;
    zcnt      = zpad_mode ? (zeros_r + pad_r) : zeros_r;
    trail     = left_justify_r ? pad_r : '0;
    b1_nxt    = lead;
    b2_nxt    = lead + PW'(has_sign_r);
    b3_nxt    = b2_nxt + zcnt;
    b4_nxt    = b3_nxt + dlen_r;
    total     = b4_nxt + trail;
    // Anything past the maximum field length is dropped.
    end_nxt   = (total > PW'(sdf_pkg::MAX_FIELD)) ? PW'(sdf_pkg::MAX_FIELD) : total;
  end

  // Highest non-zero decimal digit sets the digit count; zero has one digit.
  always_comb begin
    nd_nxt = (sdf_pkg::DIG_IDX_W+1)'(1);
    for (int k = 1; k < sdf_pkg::MAX_DIGITS; k++) begin
      if (digit[k] != 4'd0) begin
        nd_nxt = (sdf_pkg::DIG_IDX_W+1)'(k + 1);
      end
    end
  end

  // Character for the current position; digits go out most significant first.
  always_comb begin
    pos_w   = PW'(pos_r);
    dig_off = b4_r - pos_w - 1'b1;
    dig_idx = dig_off[sdf_pkg::DIG_IDX_W-1:0];
    dig_val = 4'd0;
    if (dig_idx < sdf_pkg::DIG_IDX_W'(sdf_pkg::MAX_DIGITS)) begin
      dig_val = digit[dig_idx];
    end
    if (pos_w < b1_r) begin
      emit_char = sdf_pkg::CH_SPACE;
    end else if (pos_w < b2_r) begin
      emit_char = sign_r;
    end else if (pos_w < b3_r) begin
      emit_char = sdf_pkg::CH_ZERO;
    end else if (pos_w < b4_r) begin
      emit_char = sdf_pkg::CH_ZERO + {4'd0, dig_val};
    end else begin
      emit_char = sdf_pkg::CH_SPACE;
    end
    emit_empty = (end_r == '0);
    emit_last  = emit_empty || ((pos_w + 1'b1) == end_r);
    if (emit_empty) begin
      emit_char = sdf_pkg::CH_NONE;
    end
  end

  // Sequencer and output register.
  always_comb begin
    state_nxt     = state_r;
    sign_nxt      = sign_r;
    has_sign_nxt  = has_sign_r;
    zero_nxt      = zero_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          zero_nxt = (val_ext == '0);
          if (val_neg) begin
            sign_nxt = sdf_pkg::CH_MINUS;
          end else if (force_plus_r) begin
            sign_nxt = sdf_pkg::CH_PLUS;
          end else if (space_sign_r) begin
            sign_nxt = sdf_pkg::CH_SPACE;
          end else begin
            sign_nxt = sdf_pkg::CH_NONE;
          end
          has_sign_nxt = val_neg || force_plus_r || space_sign_r;
          state_nxt    = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_stat.done) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: state_nxt = ST_SIZE;
      ST_SIZE:  state_nxt = ST_PLAN;
      ST_PLAN: begin
        pos_nxt   = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // The field boundaries are still loading in the first emit cycle.
        if (out_free && !plan_load_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = emit_char;
          out_last_nxt  = emit_last;
          out_empty_nxt = emit_empty;
          pos_nxt       = pos_r + 1'b1;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    sign_r     <= sign_nxt;
    has_sign_r <= has_sign_nxt;
    zero_r     <= zero_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    if (state_r == ST_COUNT) begin
      nd_r <= nd_nxt;
    end
    if (state_r == ST_SIZE) begin
      zeros_r <= zeros_nxt;
      dlen_r  <= dlen_nxt;
    end
    if (state_r == ST_PLAN) begin
      pad_r <= pad_nxt;
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The plan needs the padding, which in turn needs the sized counts: pad is
  // registered in the plan cycle and the boundaries are worked out from it in the cycle
  // after, so the boundary registers load on the first emit cycle before any character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_load_r <= 1'b0;
    end else begin
      plan_load_r <= (state_r == ST_PLAN);
    end
    if (plan_load_r) begin
      b1_r  <= b1_nxt;
      b2_r  <= b2_nxt;
      b3_r  <= b3_nxt;
      b4_r  <= b4_nxt;
      end_r <= end_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_char_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_empty_r;

  `include "assert_macros.svh"

  // An accepted value starts the converter and moves the sequencer into its conversion state.
  `SDF_ASSERT(a_conv_start, in_fire |=> (state_r == ST_CONV) && conv_stat.busy,
              "converter did not start on an accepted value")
  // An empty field is a single zero word that closes the field.
  `SDF_ASSERT(a_empty_word, (out_tvalid && out_tuser[0]) |-> (out_tlast && out_tdata == 8'h00),
              "empty word without last or with a character")
  // No new value is taken while characters are still being produced.
  `SDF_ASSERT(a_no_accept_emit, (state_r != ST_IDLE) |-> !in_tready,
              "input ready outside idle")

endmodule

### verif/tb_signed_decimal_field_formatter.sv
// Self-checking testbench for the signed decimal field formatter: directed rows, then random phases.
`timescale 1ns / 100ps

module tb_signed_decimal_field_formatter;

  // Cycles without any handshake or register write before the run is declared hung. The
  // slowest item is a 64-bit value, converted bit by bit before its first word, and even
  // with the receiver stalling this leaves a wide margin.
  localparam int STALL_LIMIT     = 2000;
  // Cycles run on after the last expected word, in which any extra word is still checked.
  localparam int DRAIN_CYCLES    = 150;
  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 20;

  // Shadow of the format registers, one field per register.
  typedef struct packed {
    logic [6:0] width;
    logic       lj;
    logic [6:0] prec;
    logic       plus;
    logic       space;
    logic       zpad;
    logic [1:0] len;
  } fmt_cfg_t;

  // One result word as the block should present it.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
    logic       is_empty;
  } char_word_t;

  typedef logic [7:0] char_q_t[$];

  // A directed row: format, value and, where it is obvious, the text the field must read.
  typedef struct {
    fmt_cfg_t    fmt;
    logic [63:0] value;
    bit          typed;
    string       text;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [sdf_pkg::VALUE_BITS-1:0] in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [7:0]                     out_tdata;
  logic                           out_tlast;
  logic [0:0]                     out_tuser;
  logic                           cfg_we = 1'b0;
  logic [sdf_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [sdf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  fmt_cfg_t    fmt;
  char_word_t  pending_chars[$];
  stim_row_t   stim_rows[$];
  int          mismatches = 0;

  signed_decimal_field_formatter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic fmt_cfg_t mk_format(input int w, input bit lj, input int p, input bit plus,
                                         input bit space, input bit zpad, input logic [1:0] len);
    fmt_cfg_t f;
    f.width = 7'(w);
    f.lj    = lj;
    f.prec  = 7'(p);
    f.plus  = plus;
    f.space = space;
    f.zpad  = zpad;
    f.len   = len;
    return f;
  endfunction

  // Number of value bits that the length mode keeps.
  function automatic int mode_bits(input logic [1:0] len);
    int n;
    case (len)
      sdf_pkg::LEN_INT:   n = 32;
      sdf_pkg::LEN_CHAR:  n = 8;
      sdf_pkg::LEN_SHORT: n = 16;
      default:            n = 64;
    endcase
    return (n > sdf_pkg::VALUE_BITS) ? sdf_pkg::VALUE_BITS : n;
  endfunction

  function automatic logic [63:0] mode_mask(input logic [1:0] len);
    int n;
    n = mode_bits(len);
    return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic char_q_t char_run(input logic [7:0] ch, input int n);
    char_q_t q;
    for (int k = 0; k < n; k++) q.push_back(ch);
    return q;
  endfunction

  // Text of the field that the current format gives for one input value.
  function automatic char_q_t format_value(input logic [63:0] raw);
    int          nbits, ndig, prec, width, nzero, body, nsign;
    logic [63:0] keep, cut, mag, rest;
    logic        negative, show;
    logic [7:0]  sign;
    char_q_t     sign_q, digit_q, shown_q, text;
    nbits    = mode_bits(fmt.len);
    keep     = mode_mask(fmt.len);
    cut      = raw & keep;
    negative = cut[nbits-1];
    mag      = negative ? ((~cut + 64'd1) & keep) : cut;

    // Digits come out least significant first; only the low MAX_DIGITS are kept.
    rest = mag;
    ndig = 0;
    if (rest == 64'd0) begin
      digit_q.push_back(sdf_pkg::CH_ZERO);
      ndig = 1;
    end
    while (rest != 64'd0 && ndig < sdf_pkg::MAX_DIGITS) begin
      digit_q.push_front(sdf_pkg::CH_ZERO + 8'(rest % 64'd10));
      rest = rest / 64'd10;
      ndig++;
    end

    if (negative) sign = sdf_pkg::CH_MINUS;
    else if (fmt.plus) sign = sdf_pkg::CH_PLUS;
    else if (fmt.space) sign = sdf_pkg::CH_SPACE;
    else sign = sdf_pkg::CH_NONE;
    nsign = (sign != sdf_pkg::CH_NONE) ? 1 : 0;
    if (nsign != 0) sign_q.push_back(sign);

    width = (int'(fmt.width) > sdf_pkg::MAX_FIELD) ? sdf_pkg::MAX_FIELD : int'(fmt.width);
    prec  = int'($signed(fmt.prec));
    // A zero value at precision zero prints no digits at all.
    show  = !(prec == 0 && mag == 64'd0);
    shown_q = digit_q;
    if (!show) shown_q.delete();
    nzero = (prec > ndig) ? prec - ndig : 0;
    body  = nsign + nzero + (show ? ndig : 0);

    // Left justification beats zero fill, and zero fill only applies without a precision.
    if (fmt.lj) begin
      text = {sign_q, char_run(sdf_pkg::CH_ZERO, nzero), shown_q,
              char_run(sdf_pkg::CH_SPACE, width - body)};
    end else if (fmt.zpad && prec < 0) begin
      text = {sign_q, char_run(sdf_pkg::CH_ZERO, width - nsign - ndig), digit_q};
    end else begin
      text = {char_run(sdf_pkg::CH_SPACE, width - body), sign_q,
              char_run(sdf_pkg::CH_ZERO, nzero), shown_q};
    end
    while (text.size() > sdf_pkg::MAX_FIELD) void'(text.pop_back());
    return text;
  endfunction

  // Turns a field's text into the words the block must send; no text means one empty word.
  function automatic void expect_field(input char_q_t text);
    char_word_t w;
    if (text.size() == 0) begin
      w.ch       = sdf_pkg::CH_NONE;
      w.is_last  = 1'b1;
      w.is_empty = 1'b1;
      pending_chars.push_back(w);
    end else begin
      foreach (text[i]) begin
        w.ch       = text[i];
        w.is_last  = (i == text.size() - 1);
        w.is_empty = 1'b0;
        pending_chars.push_back(w);
      end
    end
  endfunction

  function automatic void add_row(input fmt_cfg_t f, input logic [63:0] v, input bit typed,
                                  input string text);
    stim_row_t row;
    row.fmt   = f;
    row.value = v;
    row.typed = typed;
    row.text  = text;
    stim_rows.push_back(row);
  endfunction

  function automatic fmt_cfg_t pick_format(input int ph);
    int p;
    case (ph)
      // The narrowest setting and the widest one, then a zero-filled field.
      0: return mk_format(0, 1'b0, -1, 1'b0, 1'b0, 1'b0, sdf_pkg::LEN_LONG);
      1: return mk_format(127, 1'b1, 63, 1'b1, 1'b1, 1'b1, sdf_pkg::LEN_LONG);
      2: return mk_format(64, 1'b0, -1, 1'b0, 1'b1, 1'b1, sdf_pkg::LEN_INT);
      default: begin
        case ($urandom_range(0, 3))
          0:       p = -1;
          1:       p = $urandom_range(0, 10);
          2:       p = 0;
          default: p = int'($signed(7'($urandom)));
        endcase
        return mk_format(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(0, 12),
                         1'($urandom), p, 1'($urandom), 1'($urandom), 1'($urandom),
                         2'($urandom));
      end
    endcase
  endfunction

  // Values cluster on the interesting points of the current length; the bits above that
  // length are filled with noise, which the block must throw away.
  function automatic logic [63:0] pick_value();
    logic [63:0] keep, noise, base;
    keep  = mode_mask(fmt.len);
    noise = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1, 2: base = {$urandom, $urandom};
      3, 4:    base = 64'(int'($urandom_range(0, 40)) - 20);
      5:       base = ($urandom_range(0, 1) != 0) ? 64'd0 : {64{1'b1}};
      6:       base = 64'd1 << (mode_bits(fmt.len) - 1);
      default: base = keep >> 1;
    endcase
    return (noise & ~keep) | (base & keep);
  endfunction

  task automatic write_reg(input logic [sdf_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [sdf_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Writes the registers that differ from the shadow, or all of them when asked.
  task automatic load_format(input fmt_cfg_t want, input bit all_regs);
    if (all_regs || want.width != fmt.width) write_reg(sdf_pkg::REG_FIELD_WIDTH, want.width);
    if (all_regs || want.lj != fmt.lj) write_reg(sdf_pkg::REG_LEFT_JUSTIFY, 7'(want.lj));
    if (all_regs || want.prec != fmt.prec) write_reg(sdf_pkg::REG_PRECISION, want.prec);
    if (all_regs || want.plus != fmt.plus) write_reg(sdf_pkg::REG_FORCE_PLUS, 7'(want.plus));
    if (all_regs || want.space != fmt.space) write_reg(sdf_pkg::REG_SPACE_SIGN, 7'(want.space));
    if (all_regs || want.zpad != fmt.zpad) write_reg(sdf_pkg::REG_ZERO_PAD, 7'(want.zpad));
    if (all_regs || want.len != fmt.len) write_reg(sdf_pkg::REG_LENGTH_MODE, 7'(want.len));
    cfg_we <= 1'b0;
    fmt = want;
  endtask

  // Holds the input back until every word still owed has been received.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Offers one value and, once it is taken, books the words it must produce.
  task automatic push_value(input logic [63:0] v, input bit typed, input string text);
    char_q_t q;
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    if (typed) begin
      for (int i = 0; i < text.len(); i++) q.push_back(text[i]);
      expect_field(q);
    end else begin
      expect_field(format_value(v));
    end
  endtask

  // The receiver switches at random between its own stall styles: always ready,
  // randomly ready, a short regular pattern and long regular stalls.
  int unsigned rx_tick  = 0;
  int          rx_style = 0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 200 == 0) rx_style <= $urandom_range(0, 3);
    case (rx_style)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= (rx_tick % 3 != 0);
      default: out_tready <= (rx_tick % 16 >= 12);
    endcase
  end

  // Every word the block hands over is checked against the oldest booked word.
  always @(posedge clk) begin : check_words
    char_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $error("word with nothing booked: out_char %h last %b empty_res %b",
               out_tdata, out_tlast, out_tuser[0]);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, out_tdata);
          mismatches++;
        end
        if (out_tlast !== want.is_last) begin
          $error("last: expected %b, got %b", want.is_last, out_tlast);
          mismatches++;
        end
        if (out_tuser[0] !== want.is_empty) begin
          $error("empty_res: expected %b, got %b", want.is_empty, out_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // Ends the run if the block goes quiet for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    fmt_cfg_t    base;
    fmt_cfg_t    want;
    logic [63:0] minus42;
    bit          gappy;
    int          sent, burst;

    // The shadow starts at the reset format, so the first rows run without any write.
    fmt     = mk_format(0, 1'b0, -1, 1'b0, 1'b0, 1'b0, sdf_pkg::LEN_INT);
    base    = fmt;
    minus42 = 64'hFFFF_FFFF_FFFF_FFD6;

    // Plain conversions at each length, including both ends of the int, char and long
    // ranges, the lowest short value, and values whose upper bits must be cut away.
    add_row(base, 64'd0, 1'b1, "0");
    add_row(base, 64'd42, 1'b1, "42");
    add_row(base, {64{1'b1}}, 1'b1, "-1");
    add_row(base, 64'h1234_5678_8000_0000, 1'b1, "-2147483648");
    add_row(base, 64'hFFFF_FFFF_7FFF_FFFF, 1'b1, "2147483647");
    add_row(mk_format(0, 0, -1, 0, 0, 0, sdf_pkg::LEN_CHAR), 64'h80, 1'b1, "-128");
    add_row(mk_format(0, 0, -1, 0, 0, 0, sdf_pkg::LEN_CHAR), 64'h17F, 1'b1, "127");
    add_row(mk_format(0, 0, -1, 0, 0, 0, sdf_pkg::LEN_SHORT), 64'hABCD_0000_0000_8000, 1'b1,
            "-32768");
    add_row(mk_format(0, 0, -1, 0, 0, 0, sdf_pkg::LEN_SHORT), 64'hFFFF, 1'b1, "-1");
    add_row(mk_format(0, 0, -1, 0, 0, 0, sdf_pkg::LEN_LONG), 64'h8000_0000_0000_0000, 1'b1,
            "-9223372036854775808");
    add_row(mk_format(0, 0, -1, 0, 0, 0, sdf_pkg::LEN_LONG), 64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
            "9223372036854775807");
    // Sign flags; plus wins over space.
    add_row(mk_format(0, 0, -1, 1, 0, 0, sdf_pkg::LEN_LONG), 64'd0, 1'b1, "+0");
    add_row(mk_format(0, 0, -1, 0, 1, 0, sdf_pkg::LEN_LONG), 64'd5, 1'b1, " 5");
    add_row(mk_format(0, 0, -1, 1, 1, 0, sdf_pkg::LEN_LONG), 64'd5, 1'b1, "+5");
    // Zero at precision zero: no digits, so with nothing else the field is empty.
    add_row(mk_format(0, 0, 0, 0, 0, 0, sdf_pkg::LEN_INT), 64'd0, 1'b1, "");
    add_row(mk_format(3, 0, 0, 0, 0, 0, sdf_pkg::LEN_INT), 64'd0, 1'b1, "   ");
    add_row(mk_format(0, 0, 0, 1, 0, 0, sdf_pkg::LEN_INT), 64'd0, 1'b1, "+");
    // Justification and zero fill, including the cases where zero fill is ignored.
    add_row(mk_format(6, 0, -1, 0, 0, 0, sdf_pkg::LEN_INT), 64'd42, 1'b1, "    42");
    add_row(mk_format(6, 1, -1, 0, 0, 0, sdf_pkg::LEN_INT), minus42, 1'b1, "-42   ");
    add_row(mk_format(6, 0, -1, 0, 0, 1, sdf_pkg::LEN_INT), minus42, 1'b1, "-00042");
    add_row(mk_format(6, 0, 3, 0, 0, 1, sdf_pkg::LEN_INT), 64'd7, 1'b1, "   007");
    add_row(mk_format(5, 1, -1, 0, 0, 1, sdf_pkg::LEN_INT), 64'd7, 1'b1, "7    ");
    // An oversized width saturates; the largest precision fills the whole field.
    add_row(mk_format(127, 0, -1, 0, 0, 0, sdf_pkg::LEN_INT), 64'd1, 1'b0, "");
    add_row(mk_format(64, 1, 63, 1, 0, 0, sdf_pkg::LEN_LONG), 64'h8000_0000_0000_0000, 1'b0,
            "");
    // Any negative precision counts as none, so zero fill applies.
    add_row(mk_format(4, 0, -64, 0, 0, 1, sdf_pkg::LEN_INT), 64'd3, 1'b1, "0003");

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[r]) begin
      if (stim_rows[r].fmt != fmt) begin
        drain_results();
        load_format(stim_rows[r].fmt, 1'b0);
      end
      push_value(stim_rows[r].value, stim_rows[r].typed, stim_rows[r].text);
    end

    // Random phases: each starts from an idle block with every register rewritten. One
    // phase in three sends without gaps; the others send in bursts with random gaps.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      want = pick_format(ph);
      load_format(want, 1'b1);
      gappy = (ph % 3 != 0);
      sent  = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
          push_value(pick_value(), 1'b0, "");
          sent++;
        end
        if (gappy && sent < ITEMS_PER_PHASE) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
